@@ hdl/isc_pkg.sv @@
`default_nettype none
package isc_pkg;

  // Capacity of the chain and derived widths.
  localparam int unsigned MaxElems = 64;
  localparam int unsigned CountW   = $clog2(MaxElems + 1);
  localparam int unsigned ValueW   = 32;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountW-1:0]        count_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic   insert;  // an arriving element is placed into the chain
    logic   shift;   // the chain moves one place towards the output
    value_t value;   // the arriving element
  } cell_ctrl_t;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    StFill  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage
`default_nettype wire

@@ hdl/isc_in_if.sv @@
`default_nettype none
interface isc_in_if;
  logic                 valid;
  logic                 ready;
  isc_pkg::value_t      value;
  logic                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

@@ hdl/isc_out_if.sv @@
`default_nettype none
interface isc_out_if;
  logic                 valid;
  logic                 ready;
  isc_pkg::value_t      sorted_value;
  logic                 end_of_run;
  logic                 overflowed;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_value, input end_of_run,
                input overflowed, output ready);
endinterface
`default_nettype wire

@@ hdl/insertion_sorter_core.sv @@
// Streaming stable insertion sorter for signed 32-bit elements. Elements of a
// set are accepted one per cycle and are placed at once into a chain of 64
// comparing cells that keeps them in ascending order; equal values keep their
// arrival order. The item flagged last closes the set, after which the block
// emits the held values in ascending order, one per cycle while the output is
// taken, flagging the final one with end_of_run, the chain shifting one place
// towards the output per result. No element is accepted during emission.
// Elements arriving at a full chain are dropped, and every result of that set
// then carries the overflowed flag.
`default_nettype none
module insertion_sorter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  isc_in_if.sink    in_i,
  isc_out_if.source out_o
);

  isc_pkg::state_e state_q, state_d;
  isc_pkg::count_t count_q, count_d;
  logic            ovf_q, ovf_d;

  logic                in_acc, out_acc, has_room;
  isc_pkg::cell_ctrl_t ctrl;

  isc_pkg::value_t cell_val [isc_pkg::MaxElems];
  logic            cell_gt  [isc_pkg::MaxElems];

  // Handshake.
  assign in_i.ready = (state_q == isc_pkg::StFill);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign has_room   = (count_q < isc_pkg::CountW'(isc_pkg::MaxElems));

  // Broadcast to the chain.
  assign ctrl.insert = in_acc && has_room;
  assign ctrl.shift  = out_acc;
  assign ctrl.value  = in_i.value;

  // The chain of cells; cell zero faces the output.
  for (genvar i = 0; i < isc_pkg::MaxElems; i++) begin : g_cell
    logic            occ;
    logic            left_gt;
    isc_pkg::value_t left_val;
    isc_pkg::value_t right_val;

    assign occ = (isc_pkg::CountW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == isc_pkg::MaxElems - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    isc_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_gt_i   (left_gt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // Sequencer: fill until the last item, then drain the chain.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    case (state_q)
      isc_pkg::StFill: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + isc_pkg::CountW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = isc_pkg::StDrain;
          end
        end
      end
      isc_pkg::StDrain: begin
        if (out_acc) begin
          count_d = count_q - isc_pkg::CountW'(1);
          if (count_q == isc_pkg::CountW'(1)) begin
            state_d = isc_pkg::StFill;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = isc_pkg::StFill;
        count_d = '0;
        ovf_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isc_pkg::StFill;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Results come straight from the head cell.
  assign out_o.valid        = (state_q == isc_pkg::StDrain);
  assign out_o.sorted_value = cell_val[0];
  assign out_o.end_of_run   = (count_q == isc_pkg::CountW'(1));
  assign out_o.overflowed   = ovf_q;

  // A result is only offered while the chain holds something.
  a_drain_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (count_q != '0))
    else $error("result offered from an empty chain");

  // Closing a set starts emission in the next cycle.
  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last) |=> out_o.valid)
    else $error("closing item did not start emission");

  // The final result leaves the block empty and clean.
  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.end_of_run) |=> (!out_o.valid && count_q == '0 && !ovf_q))
    else $error("block not emptied after the final result");

  // An element arriving at a full chain raises the overflow flag.
  a_full_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !has_room) |=> ovf_q)
    else $error("dropped element did not raise overflow");

  // The count never exceeds capacity.
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= isc_pkg::CountW'(isc_pkg::MaxElems))
    else $error("held count beyond capacity");

endmodule
`default_nettype wire

@@ hdl/isc_cell.sv @@
`default_nettype none
module isc_cell (
  input  wire logic                clk_i,
  input  wire isc_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occ_i,
  input  wire logic                left_gt_i,
  input  wire isc_pkg::value_t     left_val_i,
  input  wire isc_pkg::value_t     right_val_i,
  output isc_pkg::value_t          val_o,
  output logic                     gt_o
);

  isc_pkg::value_t val_q, val_d;

  // The cell must make room when it is empty or holds a larger value.
  // Equal values stay put, so a new element lands after its equals.
  assign gt_o = !occ_i || (val_q > ctrl_i.value);

  // Either move towards the output, take the left neighbour's value, take
  // the new element, or hold.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = right_val_i;
    end else if (ctrl_i.insert && gt_o) begin
      val_d = left_gt_i ? left_val_i : ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

@@ sim/tb_insertion_sorter_core.sv @@
`default_nettype none
module tb_insertion_sorter_core;

  // One sorted result as the output channel carries it.
  typedef struct packed {
    isc_pkg::value_t value;
    logic            end_of_run;
    logic            overflowed;
  } sorted_result_t;

  // Kinds of element values the stimulus draws from.
  typedef enum int {
    PickAny,
    PickNarrow,
    PickCorner
  } pick_e;

  localparam int unsigned RandomItems = 30;
  localparam int unsigned DrainCycles = isc_pkg::MaxElems + 8;

  logic clk;
  logic rst_n;

  isc_in_if  in_bus ();
  isc_out_if out_bus ();

  insertion_sorter_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Mirror of the sorting chain and the results it is owed.
  isc_pkg::value_t chain_q[$];
  logic            chain_overflow;
  sorted_result_t  sorted_pending_q[$];

  int unsigned error_count;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned sets_closed;
  int unsigned overflow_sets;
  int unsigned random_items;

  // Idling controls shared between the test tasks and the two sides.
  bit tx_calm;
  bit rx_calm;
  int hold_off_cycles;

  // Clock with a period of 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generous limit on the whole run.
  initial begin
    #4_000_000;
    $display("** insertion_sorter_core: FAILED **");
    $finish;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("Mismatch at %0t: %s got %h, expected %h (result %0d)",
             $realtime, what, got, want, results_checked);
  endtask

  // Places an accepted element into the chain mirror, closing the set on last.
  function automatic void absorb_element(input isc_pkg::value_t v, input logic lst);
    int pos;
    sorted_result_t res;
    if (chain_q.size() < isc_pkg::MaxElems) begin
      // Equal values stay behind those already held.
      pos = chain_q.size();
      while (pos > 0 && chain_q[pos-1] > v) pos--;
      chain_q.insert(pos, v);
    end else begin
      chain_overflow = 1'b1;
    end
    if (lst) begin
      foreach (chain_q[k]) begin
        res.value      = chain_q[k];
        res.end_of_run = (k == chain_q.size() - 1);
        res.overflowed = chain_overflow;
        sorted_pending_q.push_back(res);
      end
      sets_closed++;
      if (chain_overflow) overflow_sets++;
      chain_q.delete();
      chain_overflow = 1'b0;
    end
  endfunction

  // Input acceptance feeds the mirror; each output item is checked in order.
  always @(posedge clk) begin
    sorted_result_t want;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      items_accepted++;
      absorb_element(in_bus.value, in_bus.last);
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (sorted_pending_q.size() == 0) begin
        report_mismatch("unexpected result, sorted_value", out_bus.sorted_value, '0);
      end else begin
        want = sorted_pending_q.pop_front();
        if (out_bus.sorted_value !== want.value)
          report_mismatch("sorted_value", out_bus.sorted_value, want.value);
        if (out_bus.end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", 32'(out_bus.end_of_run), 32'(want.end_of_run));
        if (out_bus.overflowed !== want.overflowed)
          report_mismatch("overflowed", 32'(out_bus.overflowed), 32'(want.overflowed));
      end
      results_checked++;
    end
  end

  // Receiver: random stalls, long hold-offs on request, none when calm.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after
  // it was taken.
  task automatic send_item(input isc_pkg::value_t v, input logic lst);
    if (!tx_calm && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    in_bus.last  <= lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the input idle until every owed result has come out.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sorted_pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic isc_pkg::value_t pick_value(input pick_e kind);
    isc_pkg::value_t v;
    case (kind)
      PickNarrow: v = isc_pkg::value_t'($signed($urandom_range(0, 8)) - 4);
      PickCorner: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default:    v = isc_pkg::value_t'($urandom);
    endcase
    return v;
  endfunction

  // Sends a whole set of the given size, drawing values of one kind.
  task automatic send_set(input int unsigned size, input pick_e kind);
    for (int unsigned i = 0; i < size; i++)
      send_item(pick_value(kind), i == size - 1);
  endtask

  // Extremes, sign boundaries, duplicates and single-element sets.
  task automatic test_directed();
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'haaaa_aaaa, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7fff_ffff, 1'b1);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'hffff_fffb, 1'b0);
    send_item(32'h0000_0005, 1'b1);
    wait_drained();
  endtask

  // A set that exactly fills the chain, then a set whose last two elements
  // are dropped, the closing one finding the chain full.
  task automatic test_capacity();
    send_set(isc_pkg::MaxElems, PickAny);
    send_set(isc_pkg::MaxElems + 2, PickNarrow);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering the next set.
  task automatic test_backpressure();
    tx_calm = 1'b1;
    send_set(20, PickAny);
    hold_off_cycles = 300;
    send_set(14, PickNarrow);
    send_set(6, PickAny);
    tx_calm = 1'b0;
    wait_drained();
  endtask

  // Random sets, mostly short, cut so that the total comes to exactly the plan.
  task automatic test_random_sets();
    int unsigned size;
    int unsigned roll;
    while (random_items < RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)      size = $urandom_range(1, 16);
      else if (roll < 95) size = $urandom_range(17, isc_pkg::MaxElems);
      else                size = $urandom_range(isc_pkg::MaxElems + 1, isc_pkg::MaxElems + 6);
      if (size > RandomItems - random_items) size = RandomItems - random_items;
      send_set(size, pick_e'($urandom_range(0, 2)));
      random_items += size;
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Back-to-back sets with no idling on either side.
  task automatic test_streaming();
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (20) @(negedge clk);
    send_set(1, PickAny);
    send_set(9, PickNarrow);
    send_set(4, PickAny);
    send_set(2, PickCorner);
    wait_drained();
  endtask

  // Reset, the tests in turn, then the verdict.
  initial begin
    error_count     = 0;
    items_accepted  = 0;
    results_checked = 0;
    sets_closed     = 0;
    overflow_sets   = 0;
    random_items    = 0;
    chain_overflow  = 1'b0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    hold_off_cycles = 0;
    in_bus.valid    = 1'b0;
    in_bus.value    = '0;
    in_bus.last     = 1'b0;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_capacity();
    test_backpressure();
    test_random_sets();
    test_streaming();

    wait_drained();
    repeat (DrainCycles) @(negedge clk);

    $display("Closed %0d sets from %0d accepted items, %0d of them overflowed;",
             sets_closed, items_accepted, overflow_sets);
    $display("checked %0d sorted results under random and long output stalls.",
             results_checked);
    if (error_count == 0) begin
      $display("** insertion_sorter_core: PASSED **");
    end else begin
      $display("** insertion_sorter_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
